>>> hw/rtl/gcf_pkg.sv
`default_nettype none

package gcf_pkg;

    // frame geometry
    localparam int FRAME_WIDTH  = 28;
    localparam int FRAME_HEIGHT = 28;
    localparam int COL_W        = $clog2(FRAME_WIDTH);
    localparam int ROW_W        = $clog2(FRAME_HEIGHT);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);

    // result position fields are fixed at five bits
    localparam int POS_W = 5;

    localparam int PIX_W     = 8;
    localparam int SUM_W     = 10;
    localparam int COEF_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int RGB565_W  = 16;

    // three line stores, one per row modulo three
    localparam int BANK_COUNT = 3;
    localparam int BANK_W     = 2;
    localparam logic [BANK_W-1:0] BANK_LAST = BANK_W'((FRAME_HEIGHT - 1) % BANK_COUNT);
    localparam logic [BANK_W-1:0] BANK_PREV = BANK_W'((FRAME_HEIGHT - 2) % BANK_COUNT);

    // divide by three as multiply by reciprocal, exact for sums up to 765
    localparam int GREY_SHIFT  = 11;
    localparam int GREY_RECIP  = (1 << GREY_SHIFT) / 3 + 1;
    localparam int GREY_PROD_W = SUM_W + $clog2(GREY_RECIP);

    // kernel
    localparam int TAP_COLS  = 3;
    localparam int TAP_COUNT = 9;

    // column queue, depth must be a power of two
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [COEF_W-1:0] COEF_TOP_RESET = 24'hFF0001;
    localparam logic [COEF_W-1:0] COEF_MID_RESET = 24'hFE0002;
    localparam logic [COEF_W-1:0] COEF_BOT_RESET = 24'hFF0001;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_ROW = 2'd0,
        CFG_MID_ROW = 2'd1,
        CFG_BOT_ROW = 2'd2
    } cfg_reg_t;

    // one column of the 3x3 window: rows above, at and below the result row
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } column_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        column_t          data;
    } col_item_t;

    typedef struct packed {
        logic [COEF_W-1:0] top;
        logic [COEF_W-1:0] mid;
        logic [COEF_W-1:0] bot;
    } coef_set_t;

    function automatic logic [BANK_W-1:0] bank_next(input logic [BANK_W-1:0] b);
        return (b == BANK_W'(BANK_COUNT - 1)) ? '0 : b + 1'b1;
    endfunction

    function automatic logic [BANK_W-1:0] bank_prev(input logic [BANK_W-1:0] b);
        return (b == '0) ? BANK_W'(BANK_COUNT - 1) : b - 1'b1;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gcf_front.sv
`default_nettype none

module gcf_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [gcf_pkg::PIX_W-1:0]   red,
    input  wire logic [gcf_pkg::PIX_W-1:0]   green,
    input  wire logic [gcf_pkg::PIX_W-1:0]   blue,
    output logic                             push,
    output gcf_pkg::col_item_t               push_item,
    input  wire logic                        fifo_full
);
    import gcf_pkg::*;

    // input position and line store bank of the current row
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [BANK_W-1:0] bank_reg, bank_next_q;

    // last-row flush sequencer
    logic              flush_reg, flush_next;
    logic [COL_W-1:0]  flush_col_reg, flush_col_next;

    // stage A: grey conversion and column assembly
    logic              a_valid_reg, a_valid_next;
    logic [SUM_W-1:0]  a_sum_reg;
    logic [ROW_W-1:0]  a_row_reg;
    logic [COL_W-1:0]  a_col_reg;
    logic [BANK_W-1:0] a_wbank_reg;
    logic [BANK_W-1:0] a_top_bank_reg;
    logic [BANK_W-1:0] a_mid_bank_reg;
    logic              a_write_reg;
    logic              a_push_reg;
    logic              a_top_ok_reg;
    logic              a_flush_reg;
    logic              a_last_reg;

    logic [PIX_W-1:0]  mem [BANK_COUNT][FRAME_WIDTH];
    logic [PIX_W-1:0]  rd_reg [BANK_COUNT];

    logic                   a_go;
    logic                   accept;
    logic                   flush_issue;
    logic                   pix_last;
    logic                   rd_en;
    logic [COL_W-1:0]       rd_addr;
    logic                   we;
    logic [GREY_PROD_W-1:0] grey_prod;
    logic [PIX_W-1:0]       grey;

    assign a_go        = !a_valid_reg || !a_push_reg || !fifo_full;
    assign in_stall    = flush_reg || !a_go;
    assign accept      = in_valid && !in_stall;
    assign flush_issue = flush_reg && a_go;
    assign pix_last    = (row_reg == ROW_LAST) && (col_reg == COL_LAST);
    assign rd_en       = accept || flush_issue;
    assign rd_addr     = flush_reg ? flush_col_reg : col_reg;
    assign we          = a_valid_reg && a_go && a_write_reg;

    assign grey_prod = GREY_PROD_W'(a_sum_reg) * GREY_PROD_W'(GREY_RECIP);
    assign grey      = grey_prod[GREY_SHIFT +: PIX_W];

    assign push          = a_valid_reg && a_push_reg && !fifo_full;
    assign push_item.row = a_row_reg;
    assign push_item.col = a_col_reg;
    assign push_item.last = a_last_reg;
    assign push_item.data.top = a_top_ok_reg ? rd_reg[a_top_bank_reg] : '0;
    assign push_item.data.mid = rd_reg[a_mid_bank_reg];
    assign push_item.data.bot = a_flush_reg ? '0 : grey;

    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        bank_next_q    = bank_reg;
        flush_next     = flush_reg;
        flush_col_next = flush_col_reg;
        a_valid_next   = a_valid_reg;

        if (a_go)
        begin
            a_valid_next = accept || flush_issue;
        end

        if (accept)
        begin
            if (col_reg == COL_LAST)
            begin
                col_next = '0;
                if (row_reg == ROW_LAST)
                begin
                    // frame done: wrap and start flushing the last row
                    row_next       = '0;
                    bank_next_q    = '0;
                    flush_next     = 1'b1;
                    flush_col_next = '0;
                end
                else
                begin
                    row_next    = row_reg + 1'b1;
                    bank_next_q = bank_next(bank_reg);
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end

        if (flush_issue)
        begin
            if (flush_col_reg == COL_LAST)
            begin
                flush_next = 1'b0;
            end
            else
            begin
                flush_col_next = flush_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            bank_reg      <= '0;
            flush_reg     <= 1'b0;
            flush_col_reg <= '0;
            a_valid_reg   <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            bank_reg      <= bank_next_q;
            flush_reg     <= flush_next;
            flush_col_reg <= flush_col_next;
            a_valid_reg   <= a_valid_next;
        end
    end

    // stage A payload
    always_ff @(posedge clk)
    begin
        if (a_go && accept)
        begin
            a_sum_reg      <= SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
            a_row_reg      <= row_reg - 1'b1;
            a_col_reg      <= col_reg;
            a_wbank_reg    <= bank_reg;
            a_mid_bank_reg <= bank_prev(bank_reg);
            a_top_bank_reg <= bank_next(bank_reg);
            a_write_reg    <= 1'b1;
            a_push_reg     <= (row_reg != '0);
            a_top_ok_reg   <= (row_reg > ROW_W'(1));
            a_flush_reg    <= 1'b0;
            a_last_reg     <= 1'b0;
        end
        else if (flush_issue)
        begin
            a_sum_reg      <= '0;
            a_row_reg      <= ROW_LAST;
            a_col_reg      <= flush_col_reg;
            a_wbank_reg    <= BANK_LAST;
            a_mid_bank_reg <= BANK_LAST;
            a_top_bank_reg <= BANK_PREV;
            a_write_reg    <= 1'b0;
            a_push_reg     <= 1'b1;
            a_top_ok_reg   <= 1'b1;
            a_flush_reg    <= 1'b1;
            a_last_reg     <= (flush_col_reg == COL_LAST);
        end
    end

    // line stores: one write and one registered read per bank and cycle
    always_ff @(posedge clk)
    begin
        for (int b = 0; b < BANK_COUNT; b++)
        begin
            if (we && (a_wbank_reg == BANK_W'(b)))
            begin
                mem[b][a_col_reg] <= grey;
            end
            if (rd_en)
            begin
                rd_reg[b] <= mem[b][rd_addr];
            end
        end
    end

    a_flush_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pix_last |=> flush_reg && (flush_col_reg == '0))
        else $error("flush did not start after the last pixel");

endmodule

`default_nettype wire

>>> hw/rtl/gcf_fifo.sv
`default_nettype none

module gcf_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire gcf_pkg::col_item_t push_item,
    output logic               full,
    input  wire logic          pop,
    output gcf_pkg::col_item_t head,
    output logic               head_valid
);
    import gcf_pkg::*;

    col_item_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;

    assign full       = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("column queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("column queue underflow");

endmodule

`default_nettype wire

>>> hw/rtl/gcf_back.sv
`default_nettype none

module gcf_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gcf_pkg::coef_set_t            coef,
    input  wire logic                          head_valid,
    input  wire gcf_pkg::col_item_t            head,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [gcf_pkg::PIX_W-1:0]          filtered,
    output logic [gcf_pkg::RGB565_W-1:0]       color565,
    output logic [gcf_pkg::POS_W-1:0]          out_row,
    output logic [gcf_pkg::POS_W-1:0]          out_col,
    output logic                               frame_end
);
    import gcf_pkg::*;

    // sliding window: columns left of and at the next result
    column_t           win_l_reg, win_l_next;
    column_t           win_c_reg, win_c_next;
    logic              pend_reg, pend_next;
    logic [ROW_W-1:0]  pend_row_reg, pend_row_next;
    logic              pend_last_reg, pend_last_next;

    // product stage
    logic              p_valid_reg;
    logic [PIX_W-1:0]  p_prod_reg [TAP_COUNT];
    logic [ROW_W-1:0]  p_row_reg;
    logic [COL_W-1:0]  p_col_reg;
    logic              p_last_reg;

    // output stage
    logic                 out_valid_reg;
    logic [PIX_W-1:0]     filtered_reg;
    logic [POS_W-1:0]     out_row_reg;
    logic [POS_W-1:0]     out_col_reg;
    logic                 frame_end_reg;

    logic              en;
    logic              emit;
    column_t           col_r;
    logic [ROW_W-1:0]  e_row;
    logic [COL_W-1:0]  e_col;
    logic              e_last;
    logic [PIX_W-1:0]  win_pix [TAP_COUNT];
    logic [PIX_W-1:0]  tap_w [TAP_COUNT];
    logic [PIX_W-1:0]  prod [TAP_COUNT];
    logic [PIX_W-1:0]  sum;

    assign en  = !out_valid_reg || !out_stall;
    // a pending right-edge result leaves room only for a row-start column
    assign pop = en && head_valid && (!pend_reg || (head.col == '0));

    always_comb
    begin
        win_l_next     = win_l_reg;
        win_c_next     = win_c_reg;
        pend_next      = pend_reg;
        pend_row_next  = pend_row_reg;
        pend_last_next = pend_last_reg;
        emit           = 1'b0;
        col_r          = head.data;
        e_row          = head.row;
        e_col          = head.col - 1'b1;
        e_last         = 1'b0;

        if (en && pend_reg)
        begin
            // right-edge result: right column is padding
            emit      = 1'b1;
            col_r     = '0;
            e_row     = pend_row_reg;
            e_col     = COL_LAST;
            e_last    = pend_last_reg;
            pend_next = 1'b0;
        end
        else if (pop && (head.col != '0))
        begin
            emit = 1'b1;
        end

        if (pop)
        begin
            if (head.col == '0)
            begin
                win_l_next = '0;
                win_c_next = head.data;
            end
            else
            begin
                win_l_next = win_c_reg;
                win_c_next = head.data;
                if (head.col == COL_LAST)
                begin
                    pend_next      = 1'b1;
                    pend_row_next  = head.row;
                    pend_last_next = head.last;
                end
            end
        end
    end

    always_comb
    begin
        win_pix[0] = win_l_reg.top;
        win_pix[1] = win_c_reg.top;
        win_pix[2] = col_r.top;
        win_pix[3] = win_l_reg.mid;
        win_pix[4] = win_c_reg.mid;
        win_pix[5] = col_r.mid;
        win_pix[6] = win_l_reg.bot;
        win_pix[7] = win_c_reg.bot;
        win_pix[8] = col_r.bot;
        for (int dc = 0; dc < TAP_COLS; dc++)
        begin
            tap_w[dc]              = coef.top[dc*PIX_W +: PIX_W];
            tap_w[TAP_COLS + dc]   = coef.mid[dc*PIX_W +: PIX_W];
            tap_w[2*TAP_COLS + dc] = coef.bot[dc*PIX_W +: PIX_W];
        end
        // only the low byte of the sum survives, so products wrap at eight bits
        for (int k = 0; k < TAP_COUNT; k++)
        begin
            prod[k] = PIX_W'(win_pix[k] * tap_w[k]);
        end
    end

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < TAP_COUNT; k++)
        begin
            sum = sum + p_prod_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (en)
            begin
                p_valid_reg   <= emit;
                out_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_l_reg     <= win_l_next;
        win_c_reg     <= win_c_next;
        pend_row_reg  <= pend_row_next;
        pend_last_reg <= pend_last_next;
        if (en && emit)
        begin
            for (int k = 0; k < TAP_COUNT; k++)
            begin
                p_prod_reg[k] <= prod[k];
            end
            p_row_reg  <= e_row;
            p_col_reg  <= e_col;
            p_last_reg <= e_last;
        end
        if (en && p_valid_reg)
        begin
            filtered_reg  <= sum;
            out_row_reg   <= POS_W'(p_row_reg);
            out_col_reg   <= POS_W'(p_col_reg);
            frame_end_reg <= p_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign color565  = {filtered_reg[PIX_W-1:3], filtered_reg[PIX_W-1:2],
                        filtered_reg[PIX_W-1:3]};
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign frame_end = frame_end_reg;

    a_frame_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_end_reg |->
            (out_row_reg == POS_W'(ROW_LAST)) && (out_col_reg == POS_W'(COL_LAST)))
        else $error("frame end flagged away from the last pixel");

    a_pend_follows_edge: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_reg) |-> p_valid_reg && (p_col_reg == COL_W'(FRAME_WIDTH - 2)))
        else $error("right-edge result pending without its left neighbor");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(p_valid_reg) && $stable(p_col_reg) && $stable(pend_reg))
        else $error("back end moved while the output was stalled");

endmodule

`default_nettype wire

>>> hw/rtl/gray_conv3x3_frame_filter.sv
// Streaming 3x3 convolution of a 28x28 grey frame. Each accepted RGB pixel
// (raster order) becomes grey = (red+green+blue)/3 and is kept in one of three
// line stores; results come out in raster order, one row and one pixel behind
// the input, each giving the low byte of the weighted sum, its RGB565 grey
// form, its row and column, and frame_end on the last result of the frame.
// Neighbors outside the frame count as zero. Input is taken at one pixel per
// cycle while in_stall is low; after the last pixel of a frame in_stall
// stays high while the front end reads the last row back out of the line
// stores. Results leave at up to one per cycle while out_stall is low, paced
// by the single 3x3 multiply-accumulate path in the back end; a
// four-entry column queue between front and back absorbs output stalls. The
// line stores need no clearing pass after reset. The tap registers (index 0
// top row, 1 middle, 2 bottom; signed bytes left in bits 7:0, center in 15:8,
// right in 23:16) are always ready and should be written only while the block
// is idle.
`default_nettype none

module gray_conv3x3_frame_filter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [gcf_pkg::PIX_W-1:0]         red,
    input  wire logic [gcf_pkg::PIX_W-1:0]         green,
    input  wire logic [gcf_pkg::PIX_W-1:0]         blue,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [gcf_pkg::PIX_W-1:0]              filtered,
    output logic [gcf_pkg::RGB565_W-1:0]           color565,
    output logic [gcf_pkg::POS_W-1:0]              out_row,
    output logic [gcf_pkg::POS_W-1:0]              out_col,
    output logic                                   frame_end,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gcf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gcf_pkg::COEF_W-1:0]        cfg_data
);
    import gcf_pkg::*;

    coef_set_t  coef_reg;
    logic       push;
    col_item_t  push_item;
    logic       fifo_full;
    logic       pop;
    col_item_t  head;
    logic       head_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.top <= COEF_TOP_RESET;
            coef_reg.mid <= COEF_MID_RESET;
            coef_reg.bot <= COEF_BOT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TOP_ROW: coef_reg.top <= cfg_data;
                CFG_MID_ROW: coef_reg.mid <= cfg_data;
                CFG_BOT_ROW: coef_reg.bot <= cfg_data;
                default:     ; // drop writes to unknown registers
            endcase
        end
    end

    gcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .push      (push),
        .push_item (push_item),
        .fifo_full (fifo_full)
    );

    gcf_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (fifo_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    gcf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef       (coef_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .filtered   (filtered),
        .color565   (color565),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_end  (frame_end)
    );

endmodule

`default_nettype wire
